/* rtl/microsequenced_16bit_cpu_core_assert.svh */
// Assertion macros for the microsequenced CPU core
`ifndef MICROSEQUENCED_16BIT_CPU_CORE_ASSERT_SVH
`define MICROSEQUENCED_16BIT_CPU_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define MCPU_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define MCPU_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* rtl/mcpu_pkg.sv */
// ----------------------------------------------------------------------------
// mcpu_pkg
// Types, micro-state codes and the sequencer table of the CPU core.
// ----------------------------------------------------------------------------
package mcpu_pkg;

  localparam logic [2:0] C_NONE = 3'd0;
  localparam logic [2:0] C_MEM  = 3'd1;
  localparam logic [2:0] C_BR   = 3'd2;
  localparam logic [2:0] C_ADDR = 3'd3;
  localparam logic [2:0] C_PRIV = 3'd4;
  localparam logic [2:0] C_INT  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_SSP   = 2'd1;
  localparam logic [1:0] CFG_VEC   = 2'd2;

  localparam logic [5:0] ST_FETCH = 6'd18;
  localparam logic [5:0] ST_DECODE = 6'd32;
  localparam logic [5:0] ST_VIOL = 6'd44;
  localparam logic [15:0] PSR_RESET = 16'h0002;

  typedef struct packed {
    logic       dec;
    logic [2:0] cond;
    logic [5:0] base;
  } seq_entry_t;

  typedef struct packed {
    logic       rd;
    logic       wr;
    logic [15:0] addr;
    logic [15:0] wdata;
    logic [1:0] mask;
    logic       done;
    logic [2:0] done_pri;
  } bus_t;

  typedef struct packed {
    logic [5:0]  st;
    logic [15:0] ir;
    logic        ben;
    logic        ready;
    logic        pend;
    logic        user;
  } seq_in_t;

  function automatic seq_entry_t seq_rom(input logic [5:0] s);
    seq_entry_t e;
    e = '{dec: 1'b0, cond: C_NONE, base: 6'd18};
    case (s)
      6'd0: e = '{1'b0, C_BR, 6'd18};
      6'd2: e.base = 6'd29;
      6'd3: e.base = 6'd24;
      6'd4: e = '{1'b0, C_ADDR, 6'd20};
      6'd6: e.base = 6'd25;
      6'd7: e.base = 6'd23;
      6'd8: e = '{1'b0, C_PRIV, 6'd36};
      6'd10: e.base = 6'd56;
      6'd11: e.base = 6'd60;
      6'd15: e.base = 6'd28;
      6'd16: e = '{1'b0, C_MEM, 6'd16};
      6'd17: e = '{1'b0, C_MEM, 6'd17};
      6'd18, 6'd19: e = '{1'b0, C_INT, 6'd33};
      6'd23: e.base = 6'd16;
      6'd24: e.base = 6'd17;
      6'd25: e = '{1'b0, C_MEM, 6'd25};
      6'd26: e.base = 6'd0;
      6'd28: e = '{1'b0, C_MEM, 6'd28};
      6'd29: e = '{1'b0, C_MEM, 6'd29};
      6'd32: e = '{1'b1, C_NONE, 6'd0};
      6'd33: e = '{1'b0, C_MEM, 6'd33};
      6'd34: e = '{1'b0, C_PRIV, 6'd51};
      6'd35: e.base = 6'd32;
      6'd36: e = '{1'b0, C_MEM, 6'd36};
      6'd37: e.base = 6'd41;
      6'd38: e.base = 6'd39;
      6'd39: e.base = 6'd40;
      6'd40: e = '{1'b0, C_MEM, 6'd40};
      6'd41: e = '{1'b0, C_MEM, 6'd41};
      6'd42: e.base = 6'd34;
      6'd43: e.base = 6'd47;
      6'd44: e.base = 6'd45;
      6'd45: e.base = 6'd37;
      6'd46: e.base = 6'd0;
      6'd47: e.base = 6'd48;
      6'd48: e = '{1'b0, C_MEM, 6'd48};
      6'd49: e = '{1'b0, C_PRIV, 6'd37};
      6'd50: e.base = 6'd52;
      6'd52: e = '{1'b0, C_MEM, 6'd52};
      6'd53, 6'd55, 6'd57, 6'd61, 6'd63: e.base = 6'd0;
      6'd56: e = '{1'b0, C_MEM, 6'd56};
      6'd58: e.base = 6'd25;
      6'd60: e = '{1'b0, C_MEM, 6'd60};
      6'd62: e.base = 6'd23;
      default: e = '{dec: 1'b0, cond: C_NONE, base: 6'd18};
    endcase
    return e;
  endfunction

  function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
    logic [15:0] m;
    m = 16'((32'd1 << bits) - 32'd1);
    return (v[bits-1]) ? (v | ~m) : (v & m);
  endfunction

endpackage

/* rtl/microsequenced_16bit_cpu_core.sv */
// ----------------------------------------------------------------------------
// microsequenced_16bit_cpu_core
// 16-bit byte-addressed microsequenced CPU, one micro-state per item.
// ----------------------------------------------------------------------------
// Each input item is one CPU clock tick: the core runs the work of its current
// micro-state and returns one result item with the memory request,
// interrupt acknowledge, state number, PC and halt flag. The datapath and the
// sequencer table sit between the register file and the output register, so a
// tick is accepted every cycle while the output register is free or being
// drained; throughput is one item per cycle.
module microsequenced_16bit_cpu_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: mem_rdy[0], mem_read_data[16:1], int_request[17],
  //        int_vector[25:18], int_priority[28:26]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: mem_read_req[0], mem_write_req[1], mem_address[17:2],
  //        mem_write_data[33:18], mem_byte_mask[35:34], irq_done[36],
  //        irq_done_priority[39:37], micro_state[45:40],
  //        program_counter[61:46], halted[62]
  output logic [63:0] out_tdata
);
  logic [15:0] start_r, ssp_init_r, vbase_r;
  logic [15:0] gr_r [8];
  logic [15:0] gr_nxt [8];
  logic [15:0] pc_r, ir_r, mar_r, mdr_r, psr_r, usp_r, ssp_r;
  logic [15:0] pc_nxt, ir_nxt, mar_nxt, mdr_nxt, psr_nxt, usp_nxt, ssp_nxt;
  logic ben_r, pend_r, halt_r, ben_nxt, pend_nxt, halt_nxt;
  logic [7:0] pvec_r, pvec_nxt;
  logic [2:0] ppri_r, ppri_nxt;
  logic [5:0] st_r, st_nxt, seq_nxt;
  logic out_v_r;
  logic [63:0] out_d_r;
  logic acc;

  logic ready, irq;
  logic [15:0] rdata;
  mcpu_pkg::bus_t bus;
  mcpu_pkg::seq_in_t si;
  logic [2:0] dr, br;
  logic [15:0] ra, bv, res, byt;
  logic [3:0] n;
  logic wcc;

  assign ready = in_tdata[0];
  assign rdata = in_tdata[16:1];
  assign irq = in_tdata[17];
  assign in_tready = !out_v_r || out_tready;
  assign acc = in_tvalid && in_tready;
  assign dr = ir_r[11:9];
  assign br = ir_r[8:6];
  assign ra = gr_r[br];

  always_comb begin
    for (int i = 0; i < 8; i++) gr_nxt[i] = gr_r[i];
    pc_nxt = pc_r; ir_nxt = ir_r; mar_nxt = mar_r; mdr_nxt = mdr_r;
    psr_nxt = psr_r; usp_nxt = usp_r; ssp_nxt = ssp_r;
    ben_nxt = ben_r; pend_nxt = pend_r; halt_nxt = halt_r;
    pvec_nxt = pvec_r; ppri_nxt = ppri_r;
    bus = '0; res = '0; wcc = 1'b0;
    n = ir_r[3:0];
    bv = ir_r[5] ? mcpu_pkg::sext(ir_r, 5) : gr_r[ir_r[2:0]];
    byt = mar_r[0] ? {8'h00, mdr_r[15:8]} : {8'h00, mdr_r[7:0]};
    if (!halt_r) begin
      // latch a new request first: this tick's work already sees it
      if (irq) begin
        pend_nxt = 1'b1; pvec_nxt = in_tdata[25:18]; ppri_nxt = in_tdata[28:26];
      end
      case (st_r)
        6'd1: begin res = ra + bv; wcc = 1'b1; end
        6'd5: begin res = ra & bv; wcc = 1'b1; end
        6'd9: begin res = ra ^ bv; wcc = 1'b1; end
        6'd2, 6'd3: mar_nxt = ra + mcpu_pkg::sext(ir_r, 6);
        6'd6, 6'd7, 6'd10, 6'd11: mar_nxt = ra + (mcpu_pkg::sext(ir_r, 6) << 1);
        6'd8: begin
          mar_nxt = gr_r[6]; bus.done = 1'b1; bus.done_pri = psr_r[10:8];
        end
        6'd12: pc_nxt = ra;
        6'd13: begin
          if (!ir_r[4]) res = ra << n;
          else if (ir_r[5]) res = 16'($signed(ra) >>> n);
          else res = ra >> n;
          wcc = 1'b1;
        end
        6'd14: begin res = pc_r + (mcpu_pkg::sext(ir_r, 9) << 1); wcc = 1'b1; end
        6'd15: mar_nxt = {7'd0, ir_r[7:0], 1'b0};
        6'd16, 6'd41, 6'd48: begin
          bus.wr = 1'b1; bus.addr = mar_r; bus.wdata = mdr_r; bus.mask = 2'b11;
        end
        6'd17: begin
          bus.wr = 1'b1; bus.addr = mar_r;
          if (mar_r[0]) begin bus.wdata = {mdr_r[7:0], 8'h00}; bus.mask = 2'b10; end
          else begin bus.wdata = mdr_r; bus.mask = 2'b01; end
        end
        6'd18, 6'd19: begin mar_nxt = pc_r; pc_nxt = pc_r + 16'd2; end
        6'd20: begin gr_nxt[7] = pc_r; pc_nxt = ra; end
        6'd21: begin
          gr_nxt[7] = pc_r; pc_nxt = pc_r + (mcpu_pkg::sext(ir_r, 11) << 1);
        end
        6'd22: pc_nxt = pc_r + (mcpu_pkg::sext(ir_r, 9) << 1);
        6'd23: mdr_nxt = gr_r[dr];
        6'd24: mdr_nxt = gr_r[dr] & 16'h00FF;
        6'd25, 6'd33, 6'd36, 6'd40, 6'd52, 6'd56, 6'd60: begin
          bus.rd = 1'b1; bus.addr = mar_r; mdr_nxt = rdata;
        end
        6'd27: begin res = mdr_r; wcc = 1'b1; end
        6'd28: begin bus.rd = 1'b1; bus.addr = mar_r; mdr_nxt = rdata; gr_nxt[7] = pc_r; end
        6'd29: begin bus.rd = 1'b1; bus.addr = mar_r & 16'hFFFE; mdr_nxt = rdata; end
        6'd30, 6'd38: pc_nxt = mdr_r;
        6'd31: begin res = mcpu_pkg::sext(byt, 8); wcc = 1'b1; end
        6'd32: ben_nxt = |(ir_r[11:9] & psr_r[2:0]);
        6'd34: gr_nxt[6] = gr_r[6] + 16'd2;
        6'd35: ir_nxt = mdr_r;
        6'd37: begin
          psr_nxt = (psr_r & ~16'h8700) | {5'd0, ppri_nxt, 8'd0};
          gr_nxt[6] = gr_r[6] - 16'd2; mar_nxt = gr_r[6] - 16'd2;
        end
        6'd39: begin gr_nxt[6] = gr_r[6] + 16'd2; mar_nxt = gr_r[6] + 16'd2; end
        6'd42: psr_nxt = mdr_r;
        6'd43: mdr_nxt = pc_r - 16'd2;
        6'd44: begin mdr_nxt = psr_r; halt_nxt = 1'b1; end
        6'd45: begin usp_nxt = gr_r[6]; gr_nxt[6] = ssp_r; end
        6'd47: begin gr_nxt[6] = gr_r[6] - 16'd2; mar_nxt = gr_r[6] - 16'd2; end
        6'd49: mdr_nxt = psr_r;
        6'd50: mar_nxt = vbase_r | {7'd0, pvec_nxt, 1'b0};
        6'd54: begin pc_nxt = mdr_r; pend_nxt = 1'b0; end
        6'd58, 6'd62: mar_nxt = mdr_r;
        6'd59: begin ssp_nxt = gr_r[6]; gr_nxt[6] = usp_r; end
        default: ;
      endcase
      if (wcc) begin
        gr_nxt[dr] = res;
        psr_nxt = {psr_r[15:3], res[15], res == 16'd0, !res[15] && res != 16'd0};
      end
    end
  end

  // the table sees post-tick BEN, pending flag and privilege
  assign si = '{st: st_r, ir: ir_r, ben: ben_nxt, ready: ready,
                pend: pend_nxt, user: psr_nxt[15]};

  mcpu_seq u_seq (.si(si), .nxt_state(seq_nxt));

  assign st_nxt = (halt_r || halt_nxt) ? st_r : seq_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 16'h3000; ssp_init_r <= 16'h3000; vbase_r <= 16'h0200;
    end else if (cfg_we) begin
      case (cfg_index)
        mcpu_pkg::CFG_START: start_r <= cfg_wdata;
        mcpu_pkg::CFG_SSP:   ssp_init_r <= cfg_wdata;
        mcpu_pkg::CFG_VEC:   vbase_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // reset loads the hard defaults, matching a fresh reset of the core
      for (int i = 0; i < 8; i++) gr_r[i] <= '0;
      gr_r[6] <= 16'h3000; pc_r <= 16'h3000;
      ir_r <= '0; mar_r <= '0; mdr_r <= '0; psr_r <= mcpu_pkg::PSR_RESET;
      usp_r <= '0; ssp_r <= '0; ben_r <= 1'b0; pend_r <= 1'b0; halt_r <= 1'b0;
      pvec_r <= '0; ppri_r <= '0; st_r <= mcpu_pkg::ST_FETCH;
      out_v_r <= 1'b0; out_d_r <= '0;
    end else begin
      if (acc) begin
        for (int i = 0; i < 8; i++) gr_r[i] <= gr_nxt[i];
        pc_r <= pc_nxt; ir_r <= ir_nxt; mar_r <= mar_nxt; mdr_r <= mdr_nxt;
        psr_r <= psr_nxt; usp_r <= usp_nxt; ssp_r <= ssp_nxt;
        ben_r <= ben_nxt; pend_r <= pend_nxt; halt_r <= halt_nxt;
        pvec_r <= pvec_nxt; ppri_r <= ppri_nxt; st_r <= st_nxt;
        out_d_r <= {1'b0, halt_nxt, pc_nxt, st_r, bus.done_pri, bus.done,
                    bus.mask, bus.wdata, bus.addr, bus.wr, bus.rd};
      end
      if (acc) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = out_d_r;

  logic unused_ok;
  assign unused_ok = ^{start_r, ssp_init_r, in_tdata[31:29]};

`include "microsequenced_16bit_cpu_core_assert.svh"
  // once halted, state stays at the violation state
  `MCPU_ASSERT_IMP(a_halt_state, clk, rst_n, halt_r, st_r == mcpu_pkg::ST_VIOL)
  // a stalled result holds
  `MCPU_ASSERT_NEXT(a_hold, clk, rst_n, out_v_r && !out_tready, out_v_r && $stable(out_d_r))
  // never read and write memory in one tick
  `MCPU_ASSERT_IMP(a_rw, clk, rst_n, out_v_r, !(out_d_r[0] && out_d_r[1]))
endmodule

/* rtl/mcpu_seq.sv */
// ----------------------------------------------------------------------------
// mcpu_seq
// Next micro-state selection from the sequencer table.
// ----------------------------------------------------------------------------
module mcpu_seq (
  input  mcpu_pkg::seq_in_t si,
  output logic [5:0]        nxt_state
);
  mcpu_pkg::seq_entry_t e;
  always_comb begin
    e = mcpu_pkg::seq_rom(si.st);
    nxt_state = e.base;
    if (e.dec) nxt_state = {2'b00, si.ir[15:12]};
    else if (e.cond == mcpu_pkg::C_MEM && si.ready) nxt_state = e.base | 6'd2;
    else if (e.cond == mcpu_pkg::C_BR && si.ben) nxt_state = e.base | 6'd4;
    else if (e.cond == mcpu_pkg::C_ADDR && si.ir[11]) nxt_state = e.base | 6'd1;
    else if (e.cond == mcpu_pkg::C_PRIV && si.user) nxt_state = e.base | 6'd8;
    else if (e.cond == mcpu_pkg::C_INT && si.pend) nxt_state = e.base | 6'd16;
  end
endmodule

/* dv/microsequenced_16bit_cpu_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// microsequenced_16bit_cpu_core_tb
// Tick-level check of the microsequenced CPU core against a scoreboard that
// executes the same micro-state table. Instruction words are fed on fetch
// reads so that the core runs real instruction flows, with interrupts,
// stack switches, random memory wait states and random stream back-pressure.
// ----------------------------------------------------------------------------
module microsequenced_16bit_cpu_core_tb;

  localparam logic [2:0] COND_DECODE = 3'd7;
  localparam int         LIMIT_CYCLES = 200000;
  localparam int         ITEMS_PER_PHASE = 370;

  // one result item, last field in the lowest bits
  typedef struct packed {
    logic        halted;
    logic [15:0] pc;
    logic [5:0]  ustate;
    logic [2:0]  done_pri;
    logic        done;
    logic [1:0]  mask;
    logic [15:0] wdata;
    logic [15:0] addr;
    logic        wr;
    logic        rd;
  } tick_res_t;

  // --------------------------------------------------------------------------
  // Scoreboard: runs the core one tick per accepted item, queues the result
  // --------------------------------------------------------------------------
  class tick_scoreboard;
    logic [15:0] cfg_start, cfg_ssp, cfg_vtb;
    logic [15:0] gpr [8];
    logic [15:0] pc, ir, mar, mdr, psr, usp, ssp;
    logic        ben, pend, halt;
    logic [7:0]  pvec;
    logic [2:0]  ppri;
    logic [5:0]  st;
    logic [5:0]  nxt_base [64];
    logic [2:0]  nxt_cond [64];
    tick_res_t   expected_q [$];
    int          errors;

    function new();
      int i;
      int bases [64] = '{18,18,29,24,20,18,25,23,36,18,56,60,18,18,18,28,
                         16,17,33,33,18,18,18,16,17,25,0,18,28,29,18,18,
                         0,33,51,32,36,41,39,40,40,41,34,47,45,37,0,48,
                         48,37,52,18,52,0,18,0,56,0,25,18,60,0,23,0};
      for (i = 0; i < 64; i++) begin
        nxt_base[i] = bases[i][5:0];
        nxt_cond[i] = mcpu_pkg::C_NONE;
      end
      nxt_cond[0] = mcpu_pkg::C_BR;
      nxt_cond[4] = mcpu_pkg::C_ADDR;
      nxt_cond[8] = mcpu_pkg::C_PRIV;
      nxt_cond[34] = mcpu_pkg::C_PRIV;
      nxt_cond[49] = mcpu_pkg::C_PRIV;
      nxt_cond[18] = mcpu_pkg::C_INT;
      nxt_cond[19] = mcpu_pkg::C_INT;
      nxt_cond[mcpu_pkg::ST_DECODE] = COND_DECODE;
      for (i = 0; i < 64; i++)
        if (i inside {16, 17, 25, 28, 29, 33, 36, 40, 41, 48, 52, 56, 60})
          nxt_cond[i] = mcpu_pkg::C_MEM;
      cfg_start = 16'h3000;
      cfg_ssp   = 16'h3000;
      cfg_vtb   = 16'h0200;
      errors    = 0;
      for (i = 0; i < 8; i++) gpr[i] = '0;
      gpr[6] = cfg_ssp;
      pc = cfg_start;
      ir = '0; mar = '0; mdr = '0; psr = mcpu_pkg::PSR_RESET; usp = '0; ssp = '0;
      ben = 0; pend = 0; halt = 0; pvec = '0; ppri = '0;
      st = mcpu_pkg::ST_FETCH;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        mcpu_pkg::CFG_START: cfg_start = val;
        mcpu_pkg::CFG_SSP:   cfg_ssp = val;
        mcpu_pkg::CFG_VEC:   cfg_vtb = val;
        default: ;
      endcase
    endfunction

    function logic [15:0] sx(logic [15:0] v, int bits);
      logic [15:0] m;
      m = 16'((17'd1 << bits) - 17'd1);
      return v[bits-1] ? (v | ~m) : (v & m);
    endfunction

    function void set_cc();
      logic [15:0] v;
      v = gpr[ir[11:9]];
      psr[2:0] = v[15] ? 3'b100 : (v == 16'h0 ? 3'b010 : 3'b001);
    endfunction

    function logic [15:0] alu_operand();
      return ir[5] ? sx(ir, 5) : gpr[ir[2:0]];
    endfunction

    // execute one tick on the accepted input item
    function void note_tick(logic [31:0] d);
      tick_res_t   r;
      logic        ready;
      logic [15:0] rdata, a, b, res;
      logic [3:0]  n;
      logic [2:0]  c;
      logic [5:0]  nx;
      ready = d[0];
      rdata = d[16:1];
      r = '0;
      r.ustate = st;
      if (!halt) begin
        if (d[17]) begin
          pend = 1;
          pvec = d[25:18];
          ppri = d[28:26];
        end
        case (st)
          1: begin gpr[ir[11:9]] = gpr[ir[8:6]] + alu_operand(); set_cc(); end
          5: begin gpr[ir[11:9]] = gpr[ir[8:6]] & alu_operand(); set_cc(); end
          9: begin gpr[ir[11:9]] = gpr[ir[8:6]] ^ alu_operand(); set_cc(); end
          2, 3: mar = gpr[ir[8:6]] + sx(ir, 6);
          6, 7, 10, 11: mar = gpr[ir[8:6]] + (sx(ir, 6) << 1);
          8: begin
            mar = gpr[6];
            r.done = 1;
            r.done_pri = psr[10:8];
          end
          12: pc = gpr[ir[8:6]];
          13: begin
            a = gpr[ir[8:6]];
            n = ir[3:0];
            if (ir[4]) begin
              res = a >> n;
              if (ir[5] && a[15] && n != 0) res = res | (16'hFFFF << (16 - n));
            end else begin
              res = a << n;
            end
            gpr[ir[11:9]] = res;
            set_cc();
          end
          14: begin gpr[ir[11:9]] = pc + (sx(ir, 9) << 1); set_cc(); end
          15: mar = {7'b0, ir[7:0], 1'b0};
          16, 41, 48: begin r.wr = 1; r.addr = mar; r.wdata = mdr; r.mask = 2'b11; end
          17: begin
            r.wr = 1;
            r.addr = mar;
            if (mar[0]) begin r.wdata = {mdr[7:0], 8'h00}; r.mask = 2'b10; end
            else begin r.wdata = mdr; r.mask = 2'b01; end
          end
          18, 19: begin mar = pc; pc = pc + 16'd2; end
          20: begin b = gpr[ir[8:6]]; gpr[7] = pc; pc = b; end
          21: begin gpr[7] = pc; pc = pc + (sx(ir, 11) << 1); end
          22: pc = pc + (sx(ir, 9) << 1);
          23: mdr = gpr[ir[11:9]];
          24: mdr = gpr[ir[11:9]] & 16'h00FF;
          25, 33, 36, 40, 52, 56, 60: begin r.rd = 1; r.addr = mar; mdr = rdata; end
          27: begin gpr[ir[11:9]] = mdr; set_cc(); end
          28: begin r.rd = 1; r.addr = mar; mdr = rdata; gpr[7] = pc; end
          29: begin r.rd = 1; r.addr = {mar[15:1], 1'b0}; mdr = rdata; end
          30, 38: pc = mdr;
          31: begin
            b = mar[0] ? {8'h00, mdr[15:8]} : {8'h00, mdr[7:0]};
            gpr[ir[11:9]] = sx(b, 8);
            set_cc();
          end
          32: ben = |(ir[11:9] & psr[2:0]);
          34: gpr[6] = gpr[6] + 16'd2;
          35: ir = mdr;
          37: begin
            psr = (psr & ~16'h8700) | {5'b0, ppri, 8'h00};
            gpr[6] = gpr[6] - 16'd2;
            mar = gpr[6];
          end
          39: begin gpr[6] = gpr[6] + 16'd2; mar = gpr[6]; end
          42: psr = mdr;
          43: mdr = pc - 16'd2;
          44: begin mdr = psr; halt = 1; end
          45: begin usp = gpr[6]; gpr[6] = ssp; end
          47: begin gpr[6] = gpr[6] - 16'd2; mar = gpr[6]; end
          49: mdr = psr;
          50: mar = cfg_vtb | {7'b0, pvec, 1'b0};
          54: begin pc = mdr; pend = 0; end
          58, 62: mar = mdr;
          59: begin ssp = gpr[6]; gpr[6] = usp; end
          default: ;
        endcase
        if (!halt) begin
          c = nxt_cond[st];
          nx = nxt_base[st];
          if (c == COND_DECODE) nx = {2'b00, ir[15:12]};
          else if (c == mcpu_pkg::C_MEM && ready) nx = nx | 6'd2;
          else if (c == mcpu_pkg::C_BR && ben) nx = nx | 6'd4;
          else if (c == mcpu_pkg::C_ADDR && ir[11]) nx = nx | 6'd1;
          else if (c == mcpu_pkg::C_PRIV && psr[15]) nx = nx | 6'd8;
          else if (c == mcpu_pkg::C_INT && pend) nx = nx | 6'd16;
          st = nx;
        end
      end
      r.pc = pc;
      r.halted = halt;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    task cmp(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(tick_res_t got);
      tick_res_t want;
      if (expected_q.size() == 0) begin
        report("result item with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      cmp("mem_read_req", got.rd, want.rd);
      cmp("mem_write_req", got.wr, want.wr);
      cmp("mem_address", got.addr, want.addr);
      cmp("mem_write_data", got.wdata, want.wdata);
      cmp("mem_byte_mask", got.mask, want.mask);
      cmp("irq_done", got.done, want.done);
      cmp("irq_done_priority", got.done_pri, want.done_pri);
      cmp("micro_state", got.ustate, want.ustate);
      cmp("program_counter", got.pc, want.pc);
      cmp("halted", got.halted, want.halted);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and the core
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  // tdata: mem_rdy[0], mem_read_data[16:1], int_request[17],
  //        int_vector[25:18], int_priority[28:26]
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // tdata: mem_read_req[0], mem_write_req[1], mem_address[17:2],
  //        mem_write_data[33:18], mem_byte_mask[35:34], irq_done[36],
  //        irq_done_priority[39:37], micro_state[45:40],
  //        program_counter[61:46], halted[62]
  logic [63:0] out_tdata;

  microsequenced_16bit_cpu_core dut (.*);

  tick_scoreboard tick_sb = new();

  int  send_idle_pct;
  int  recv_stall_pct;
  int  guided_instrs;    // instruction words still fed in opcode order
  int  guided_op;
  bit  allow_halt;       // permit RTI from user mode (sticky halt) near the end
  int  cycle_count;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Drop the run if it stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Random receiver back-pressure, per the phase's stall rate.
  always @(posedge clk)
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // Check each accepted result item.
  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) tick_sb.check_result(tick_res_t'(out_tdata[62:0]));

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Build an instruction word. Guided words walk every opcode with all-ones,
  // all-zeros or mixed field values; otherwise opcodes are random. RTI in user mode halts the
  // core for good, so hold it back until the end of the run.
  function automatic logic [15:0] next_instr();
    logic [3:0]  op;
    logic [11:0] fields;
    if (guided_instrs > 0) begin
      op = guided_op[3:0];
      fields = guided_op[0] ? 12'hFFF : (guided_op[1] ? 12'h000 : 12'hA3F);
      guided_op++;
      guided_instrs--;
    end else begin
      op = 4'($urandom_range(0, 15));
      fields = 12'($urandom);
    end
    if (op == 4'd8 && tick_sb.psr[15] && !allow_halt) op = 4'd1;
    return {op, fields};
  endfunction

  // Shape the next tick from the state the core will be in when it takes it.
  function automatic logic [31:0] next_tick();
    logic        ready;
    logic [15:0] rdata;
    logic        req;
    ready = (guided_instrs > 0) ? 1'b1 : ($urandom_range(0, 99) < 60);
    rdata = 16'($urandom);
    if (tick_sb.st == 6'd33) rdata = next_instr();
    // status word popped by RTI: user mode now and then
    if (tick_sb.st == 6'd40) rdata[15] = ($urandom_range(0, 3) == 0);
    req = ($urandom_range(0, 99) < 3);
    return {3'b000, 3'($urandom), 8'($urandom), req, rdata, ready};
  endfunction

  task automatic send_tick();
    logic [31:0] d;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    d = next_tick();
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tick_sb.note_tick(d);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tick_sb.write_reg(idx, val);
  endtask

  // Hold until every expected result is in, then let the pipe settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (tick_sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int p, i;
    int send_pcts [4] = '{0, 54, 0, 27};
    int stall_pcts [4] = '{0, 0, 54, 27};
    logic [15:0] cfg_vals [4][3];
    cfg_vals[0] = '{16'h0000, 16'h0000, 16'h0000};
    cfg_vals[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    cfg_vals[2] = '{16'($urandom), 16'($urandom), 16'($urandom)};
    cfg_vals[3] = '{16'h3000, 16'h3000, 16'h0200};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = mcpu_pkg::CFG_START;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    guided_instrs = 0;
    guided_op = 0;
    allow_halt = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (p = 0; p < 4; p++) begin
      // write every register while the core is idle
      for (i = 0; i < 3; i++) write_cfg(2'(i), cfg_vals[p][i]);
      cfg_we <= 1'b0;
      @(posedge clk);
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = stall_pcts[p];
      // the first phase opens with every opcode in order, no wait states
      if (p == 0) guided_instrs = 16;
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        allow_halt = (p == 3) && (i > ITEMS_PER_PHASE - 80);
        send_tick();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (tick_sb.errors == 0 && tick_sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/mcpu_pkg.sv
rtl/mcpu_seq.sv
rtl/microsequenced_16bit_cpu_core.sv
dv/microsequenced_16bit_cpu_core_tb.sv
